// ----- design/sfes_pkg.sv -----
// ----------------------------------------------------------------------------
// sfes_pkg: shared types and constants of the sprite frame event sequencer
// Item formats, item kinds, configuration register indexes and the
// operation codes of the shared timer arithmetic unit.
// ----------------------------------------------------------------------------
package sfes_pkg;

    // Default table depths
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_MAX_EVENTS = 16;

    // Most events fired by one tick
    localparam int EVENTS_PER_TICK = 16;
    localparam int FIRED_W         = $clog2(EVENTS_PER_TICK + 1);

    // Item kinds
    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_LOAD_FRAME = 2'd1;
    localparam logic [1:0] KIND_LOAD_EVENT = 2'd2;
    localparam logic [1:0] KIND_RESTART    = 2'd3;

    // Configuration register indexes
    localparam int         CFG_INDEX_W     = 2;
    localparam logic [1:0] CFG_LOOPING     = 2'd0;
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd1;
    localparam logic [1:0] CFG_EVENT_COUNT = 2'd2;
    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd3;
    localparam int         CFG_DATA_W      = 12;

    // Result kinds
    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_EVENT  = 1'b1;

    // Shared arithmetic unit operations
    typedef enum logic {
        OP_ADD_SAT,
        OP_CMP_GE
    } alu_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] delta_time;
        logic [3:0]  entry_index;
        logic [31:0] entry_time;
        logic [7:0]  sheet_position;
        logic [7:0]  event_code;
    } cmd_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  fired_event;
        logic [3:0]  frame_index;
        logic [19:0] source_x;
        logic        just_finished;
        logic        finished;
        logic        last;
    } res_t;

endpackage

// ----- design/sprite_frame_event_sequencer.sv -----
// ----------------------------------------------------------------------------
// sprite_frame_event_sequencer: timed sprite frame and event sequencer
// Load items fill the frame and event tables, restart items clear the
// playback state, and tick items advance the timers, fire due events and
// step the frame, ending with one status item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | sfes_pkg::cmd_t
//  res     | out       | res_valid / res_stall  | sfes_pkg::res_t
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
//  Load and restart items complete in the idle state. A tick fires at most 16
//  events and may be held by any output stall. It runs as a sequence of steps,
//  since one shared adder/comparator does both timer adds and every compare
//  and each event waits for the event memory's registered read.
//  cmd_stall is high while a tick is in progress. rst_n clears timers, frame,
//  flags, event pointer and registers; the tables are undefined until loaded.
//  A result waits in the output register while res_stall is high.
// ----------------------------------------------------------------------------
module sprite_frame_event_sequencer #(
    parameter int MAX_FRAMES = sfes_pkg::DEF_MAX_FRAMES,
    parameter int MAX_EVENTS = sfes_pkg::DEF_MAX_EVENTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  sfes_pkg::cmd_t                   cmd,
    output logic                             res_valid,
    input  logic                             res_stall,
    output sfes_pkg::res_t                   res,
    input  logic                             cfg_we,
    input  logic [sfes_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfes_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfes_pkg::*;

    // Widths that follow from the table depths
    localparam int FI_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int EI_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int NE_W = $clog2(MAX_EVENTS + 1);
    localparam int FC_W = ($clog2(MAX_FRAMES + 1) > 5) ? $clog2(MAX_FRAMES + 1) : 5;
    localparam int EC_W = ($clog2(MAX_EVENTS + 1) > 5) ? $clog2(MAX_EVENTS + 1) : 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_FT,
        S_ADD_AT,
        S_EV_CHECK,
        S_EV_EMIT,
        S_EV_WAIT,
        S_FR_CHECK,
        S_FR_WAIT,
        S_STATUS
    } state_t;

    // Configuration registers
    logic        looping_reg;
    logic [4:0]  frame_count_reg;
    logic [4:0]  event_count_reg;
    logic [11:0] frame_width_reg;

    // Sequencer state
    state_t             state_reg,         state_next;
    logic [15:0]        dt_reg,            dt_next;
    logic [FI_W-1:0]    current_frame_reg, current_frame_next;
    logic [31:0]        frame_timer_reg,   frame_timer_next;
    logic [31:0]        anim_timer_reg,    anim_timer_next;
    logic [NE_W-1:0]    next_event_reg,    next_event_next;
    logic               ended_reg,         ended_next;
    logic               just_reg,          just_next;
    logic [FIRED_W-1:0] fired_reg,         fired_next;
    logic               res_valid_reg,     res_valid_next;
    res_t               res_reg,           res_next;

    // Shared unit and table connections
    alu_op_t     alu_op;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [31:0] alu_res;
    logic        alu_ge;

    logic        cmd_accept;
    logic        frame_we;
    logic        event_we;
    logic [31:0] frame_duration;
    logic [7:0]  frame_position;
    logic [31:0] event_time;
    logic [7:0]  event_id;

    logic [FC_W-1:0] fc_ext;
    logic [FC_W-1:0] fcount;
    logic [FC_W-1:0] cf_plus;
    logic [EC_W-1:0] ec_ext;
    logic [EC_W-1:0] ecount;
    logic            out_free;
    logic [19:0]     product;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != S_IDLE);

    // Load writes land at the accepting edge; slots beyond the depth drop
    assign frame_we = cmd_accept && (cmd.kind == KIND_LOAD_FRAME)
                      && (int'(cmd.entry_index) < MAX_FRAMES);
    assign event_we = cmd_accept && (cmd.kind == KIND_LOAD_EVENT)
                      && (int'(cmd.entry_index) < MAX_EVENTS);

    // Clamp the counts to the table depths; a frame count of zero acts as one
    assign fc_ext  = FC_W'(frame_count_reg);
    assign fcount  = (fc_ext == '0) ? FC_W'(1)
                   : ((fc_ext > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : fc_ext);
    assign cf_plus = FC_W'(current_frame_reg) + FC_W'(1);
    assign ec_ext  = EC_W'(event_count_reg);
    assign ecount  = (ec_ext > EC_W'(MAX_EVENTS)) ? EC_W'(MAX_EVENTS) : ec_ext;

    // The output register can take a new item when empty or being drained
    assign out_free = !res_valid_reg || !res_stall;

    // Source offset of the current frame: sheet column times frame width
    assign product = 20'(frame_position) * 20'(frame_width_reg);

    sfes_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    sfes_tables #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_EVENTS (MAX_EVENTS),
        .FI_W       (FI_W),
        .EI_W       (EI_W)
    ) u_tables (
        .clk            (clk),
        .wr_item        (cmd),
        .frame_we       (frame_we),
        .event_we       (event_we),
        .frame_raddr    (current_frame_reg),
        .event_raddr    (next_event_reg[EI_W-1:0]),
        .frame_duration (frame_duration),
        .frame_position (frame_position),
        .event_time     (event_time),
        .event_id       (event_id)
    );

    // Feed the shared unit according to the sequencer step
    always_comb
    begin
        alu_op = OP_ADD_SAT;
        alu_a  = frame_timer_reg;
        alu_b  = {16'd0, dt_reg};
        case (state_reg)
            S_ADD_FT:
            begin
                alu_op = OP_ADD_SAT;
                alu_a  = frame_timer_reg;
                alu_b  = {16'd0, dt_reg};
            end
            S_ADD_AT:
            begin
                alu_op = OP_ADD_SAT;
                alu_a  = anim_timer_reg;
                alu_b  = {16'd0, dt_reg};
            end
            S_EV_CHECK:
            begin
                alu_op = OP_CMP_GE;
                alu_a  = anim_timer_reg;
                alu_b  = event_time;
            end
            S_FR_CHECK:
            begin
                alu_op = OP_CMP_GE;
                alu_a  = frame_timer_reg;
                alu_b  = frame_duration;
            end
            default:
            begin
                alu_op = OP_ADD_SAT;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next         = state_reg;
        dt_next            = dt_reg;
        current_frame_next = current_frame_reg;
        frame_timer_next   = frame_timer_reg;
        anim_timer_next    = anim_timer_reg;
        next_event_next    = next_event_reg;
        ended_next         = ended_reg;
        just_next          = just_reg;
        fired_next         = fired_reg;
        res_valid_next     = res_valid_reg && res_stall;
        res_next           = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.kind)
                        KIND_TICK:
                        begin
                            dt_next    = cmd.delta_time;
                            state_next = S_ADD_FT;
                        end
                        KIND_RESTART:
                        begin
                            current_frame_next = '0;
                            frame_timer_next   = '0;
                            anim_timer_next    = '0;
                            next_event_next    = '0;
                            ended_next         = 1'b0;
                        end
                        default:
                        begin
                            // loads are written straight into the tables
                        end
                    endcase
                end
            end

            S_ADD_FT:
            begin
                frame_timer_next = alu_res;
                state_next       = S_ADD_AT;
            end

            S_ADD_AT:
            begin
                anim_timer_next = alu_res;
                fired_next      = '0;
                just_next       = 1'b0;
                state_next      = S_EV_CHECK;
            end

            // Fire events in table order up to the event count or 16; stop at the first not yet due
            S_EV_CHECK:
            begin
                if ((fired_reg < FIRED_W'(EVENTS_PER_TICK))
                    && (EC_W'(next_event_reg) < ecount) && alu_ge)
                begin
                    state_next = S_EV_EMIT;
                end
                else
                begin
                    state_next = S_FR_CHECK;
                end
            end

            S_EV_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.result_kind = RES_EVENT;
                    res_next.fired_event = event_id;
                    next_event_next      = next_event_reg + NE_W'(1);
                    fired_next           = fired_reg + FIRED_W'(1);
                    state_next           = S_EV_WAIT;
                end
            end

            // Wait here for the event memory to read the new slot
            S_EV_WAIT:
            begin
                state_next = S_EV_CHECK;
            end

            // Advance the frame when its duration has expired; after the last frame loop back or end
            S_FR_CHECK:
            begin
                if (alu_ge)
                begin
                    if (cf_plus < fcount)
                    begin
                        frame_timer_next   = '0;
                        current_frame_next = current_frame_reg + FI_W'(1);
                    end
                    else
                    begin
                        just_next = !ended_reg;
                        if (looping_reg)
                        begin
                            frame_timer_next   = '0;
                            current_frame_next = '0;
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                end
                state_next = S_FR_WAIT;
            end

            // Wait here for the frame memory to read the new frame
            S_FR_WAIT:
            begin
                state_next = S_STATUS;
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next               = '0;
                    res_next.result_kind   = RES_STATUS;
                    res_next.frame_index   = 4'(current_frame_reg);
                    res_next.source_x      = product;
                    res_next.just_finished = just_reg;
                    res_next.finished      = ended_reg;
                    res_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            dt_reg            <= '0;
            current_frame_reg <= '0;
            frame_timer_reg   <= '0;
            anim_timer_reg    <= '0;
            next_event_reg    <= '0;
            ended_reg         <= 1'b0;
            just_reg          <= 1'b0;
            fired_reg         <= '0;
            res_valid_reg     <= 1'b0;
            res_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            dt_reg            <= dt_next;
            current_frame_reg <= current_frame_next;
            frame_timer_reg   <= frame_timer_next;
            anim_timer_reg    <= anim_timer_next;
            next_event_reg    <= next_event_next;
            ended_reg         <= ended_next;
            just_reg          <= just_next;
            fired_reg         <= fired_next;
            res_valid_reg     <= res_valid_next;
            res_reg           <= res_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            looping_reg     <= 1'b0;
            frame_count_reg <= 5'd1;
            event_count_reg <= 5'd0;
            frame_width_reg <= 12'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOOPING:     looping_reg     <= cfg_data[0];
                CFG_FRAME_COUNT: frame_count_reg <= cfg_data[4:0];
                CFG_EVENT_COUNT: event_count_reg <= cfg_data[4:0];
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/sfes_alu.sv -----
// ----------------------------------------------------------------------------
// sfes_alu: shared 32-bit timer arithmetic unit
// One adder serves both the saturating timer add and the >= compare
// (a + ~b + 1, carry out set when a >= b).
// ----------------------------------------------------------------------------
module sfes_alu (
    input  sfes_pkg::alu_op_t op,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       res,
    output logic              ge
);
    import sfes_pkg::*;

    logic [31:0] b_op;
    logic [32:0] sum;

    assign b_op = (op == OP_CMP_GE) ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + {32'd0, (op == OP_CMP_GE)};

    // saturate on carry out of the add
    assign res = ((op == OP_ADD_SAT) && sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
    assign ge  = sum[32];

endmodule

// ----- design/sfes_tables.sv -----
// ----------------------------------------------------------------------------
// sfes_tables: frame and event table memories
// Frame memory holds duration and sheet column, event memory holds fire
// time and event id. One write and one registered read port each.
// ----------------------------------------------------------------------------
module sfes_tables #(
    parameter int MAX_FRAMES = 16,
    parameter int MAX_EVENTS = 16,
    parameter int FI_W       = 4,
    parameter int EI_W       = 4
) (
    input  logic              clk,
    input  sfes_pkg::cmd_t    wr_item,
    input  logic              frame_we,
    input  logic              event_we,
    input  logic [FI_W-1:0]   frame_raddr,
    input  logic [EI_W-1:0]   event_raddr,
    output logic [31:0]       frame_duration,
    output logic [7:0]        frame_position,
    output logic [31:0]       event_time,
    output logic [7:0]        event_id
);
    import sfes_pkg::*;

    logic [39:0] frame_mem [MAX_FRAMES];
    logic [39:0] event_mem [MAX_EVENTS];
    logic [39:0] frame_rd_reg;
    logic [39:0] event_rd_reg;

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[FI_W'(wr_item.entry_index)] <= {wr_item.entry_time,
                                                     wr_item.sheet_position};
        end
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (event_we)
        begin
            event_mem[EI_W'(wr_item.entry_index)] <= {wr_item.entry_time,
                                                     wr_item.event_code};
        end
        event_rd_reg <= event_mem[event_raddr];
    end

    assign frame_duration = frame_rd_reg[39:8];
    assign frame_position = frame_rd_reg[7:0];
    assign event_time     = event_rd_reg[39:8];
    assign event_id       = event_rd_reg[7:0];

endmodule
